/* hdl/pbmd_pkg.sv */
// shared widths, reset values and register indexes for the balance motor pid
// no dependencies; imported by the divider, the top level and the checker
`timescale 1ns / 1ps

package pbmd_pkg;

    localparam int ANGLE_W   = 16;
    localparam int ERR_W     = 17;
    localparam int DIFF_W    = 18;
    localparam int GAIN_W    = 16;
    localparam int INTEG_W   = 32;
    localparam int MUL_B_W   = 32;
    localparam int PROD_W    = GAIN_W + 1 + MUL_B_W;
    localparam int SUM_W     = 52;
    localparam int FRAC_W    = 16;
    localparam int KD_MAG_W  = 33;
    localparam int DIVIDEND_W = KD_MAG_W + FRAC_W;
    localparam int DIVISOR_W = 16;
    localparam int DIV_CNT_W = $clog2(DIVIDEND_W + 1);
    localparam int CMD_W     = 16;
    localparam int CLIM_W    = 15;
    localparam int PWM_W     = 10;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 16;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 32;

    typedef enum logic [IDX_W-1:0] {
        REG_SETPOINT      = 3'd0,
        REG_GAIN_P        = 3'd1,
        REG_GAIN_I        = 3'd2,
        REG_GAIN_D        = 3'd3,
        REG_TICK_PERIOD   = 3'd4,
        REG_DEADZONE      = 3'd5,
        REG_PWM_LIMIT     = 3'd6,
        REG_COMMAND_LIMIT = 3'd7
    } t_reg_idx;

    localparam logic [ANGLE_W-1:0] RST_SETPOINT = 16'd0;
    localparam logic [GAIN_W-1:0]  RST_GAIN_P   = 16'd7424;
    localparam logic [GAIN_W-1:0]  RST_GAIN_I   = 16'd3098;
    localparam logic [GAIN_W-1:0]  RST_GAIN_D   = 16'd4454;
    localparam logic [GAIN_W-1:0]  RST_TICK     = 16'd655;
    localparam logic [PWM_W-1:0]   RST_DEADZONE = 10'd20;
    localparam logic [PWM_W-1:0]   RST_PWM_LIM  = 10'd500;
    localparam logic [CLIM_W-1:0]  RST_CMD_LIM  = 15'd999;

    // result item layout inside m_axis_tdata
    localparam int OUT_CMD_LSB = 0;
    localparam int OUT_PWM_LSB = CMD_W;
    localparam int OUT_FWD_BIT = CMD_W + PWM_W;
    localparam int OUT_DZ_BIT  = CMD_W + PWM_W + 1;

endpackage

/* hdl/pbmd_div.sv */
// unsigned restoring divider, one quotient bit per cycle
// depends on pbmd_pkg for operand widths
`timescale 1ns / 1ps

module pbmd_div
    import pbmd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0] w_shift;
    logic [DIVISOR_W:0] w_trial;
    logic               w_fits;

    // bring down the next dividend bit and try the subtraction
    assign w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_trial = w_shift - {1'b0, i_divisor};
    assign w_fits  = (w_shift >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVIDEND_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= w_fits ? w_trial[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], w_fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hdl/pid_balance_motor_drive.sv */
// pid controller for a balance robot: error, saturating integral, derivative,
// command clamp, deadzone and pwm limit; uses pbmd_pkg and pbmd_div
`timescale 1ns / 1ps

// usage
//   slave stream s_axis_*: one item per control tick, tdata[15:0] is the
//   measured tilt angle (signed q8.8)
//   master stream m_axis_*: one result item per input item
//   config channel i_cfg_*: register index and data, always ready; write
//   only while no item is in flight
// timing
//   one shared 17x32 multiplier runs four products in sequence, then a
//   restoring divider forms the derivative one quotient bit per cycle
//   over the 49-bit dividend; with tick_period zero the derivative is
//   skipped; each item passes accept, the four products, the divider
//   launch and wait, sign and magnitude, then the output step
//   a new item is taken only after the last one has left the sequencer;
//   s_axis_tready is high only while the sequencer is idle
// reset
//   synchronous active low; clears integral, previous error, direction
//   (backward) and loads the default gains and limits
// stalls
//   the result sits in an output register; a new item is taken while it
//   waits, and the sequencer holds its last step until the register frees
module pid_balance_motor_drive
    import pbmd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // [15:0] measured_angle
    // result item
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // [15:0] command, [25:16] pwm_duty,
                                                // [26] forward, [27] in_deadzone,
                                                // [31:28] zero
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IDX_W-1:0]    i_cfg_addr,
    input  logic [CFG_W-1:0]    i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDT,     // e*dt
        S_INT,     // integral update, kp*e
        S_P,       // start the sum, ki*integral
        S_I,       // add integral term, kd*(e - previous)
        S_DST,     // launch derivative division
        S_DWT,     // wait for quotient, add derivative
        S_ABS,     // sign and magnitude of the sum
        S_FIN      // clamp, deadzone, pwm, output
    } t_state;

    // configuration registers
    logic [ANGLE_W-1:0] r_setpoint;
    logic [GAIN_W-1:0]  r_gain_p;
    logic [GAIN_W-1:0]  r_gain_i;
    logic [GAIN_W-1:0]  r_gain_d;
    logic [GAIN_W-1:0]  r_tick;
    logic [PWM_W-1:0]   r_deadzone;
    logic [PWM_W-1:0]   r_pwm_lim;
    logic [CLIM_W-1:0]  r_cmd_lim;

    // controller state and work registers
    t_state                r_state;
    logic [INTEG_W-1:0]    r_integ;
    logic [ERR_W-1:0]      r_prev;
    logic                  r_dir;
    logic [ERR_W-1:0]      r_err;
    logic [DIFF_W-1:0]     r_diff;
    logic [PROD_W-1:0]     r_prod;
    logic [SUM_W-1:0]      r_sum;
    logic                  r_neg;
    logic                  r_dneg;
    logic                  r_ovalid;
    logic [M_DATA_W-1:0]   r_odata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= RST_SETPOINT;
            r_gain_p   <= RST_GAIN_P;
            r_gain_i   <= RST_GAIN_I;
            r_gain_d   <= RST_GAIN_D;
            r_tick     <= RST_TICK;
            r_deadzone <= RST_DEADZONE;
            r_pwm_lim  <= RST_PWM_LIM;
            r_cmd_lim  <= RST_CMD_LIM;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_SETPOINT:      r_setpoint <= i_cfg_wdata;
                REG_GAIN_P:        r_gain_p   <= i_cfg_wdata;
                REG_GAIN_I:        r_gain_i   <= i_cfg_wdata;
                REG_GAIN_D:        r_gain_d   <= i_cfg_wdata;
                REG_TICK_PERIOD:   r_tick     <= i_cfg_wdata;
                REG_DEADZONE:      r_deadzone <= i_cfg_wdata[PWM_W-1:0];
                REG_PWM_LIMIT:     r_pwm_lim  <= i_cfg_wdata[PWM_W-1:0];
                REG_COMMAND_LIMIT: r_cmd_lim  <= i_cfg_wdata[CLIM_W-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier: unsigned 16-bit gain/dt times signed 32-bit operand
    logic [GAIN_W-1:0]   w_mul_a;
    logic [MUL_B_W-1:0]  w_mul_b;
    logic [PROD_W-1:0]   w_prod;

    always_comb begin
        w_mul_a = r_gain_p;
        w_mul_b = {{(MUL_B_W-ERR_W){r_err[ERR_W-1]}}, r_err};
        case (r_state)
            S_EDT: begin
                w_mul_a = r_tick;
            end
            S_P: begin
                w_mul_a = r_gain_i;
                w_mul_b = r_integ;
            end
            S_I: begin
                w_mul_a = r_gain_d;
                w_mul_b = {{(MUL_B_W-DIFF_W){r_diff[DIFF_W-1]}}, r_diff};
            end
            default: ;
        endcase
    end

    // operands widened to the full product width before the multiply
    assign w_prod = $signed({1'b0, w_mul_a})
                  * $signed({{(PROD_W-MUL_B_W){w_mul_b[MUL_B_W-1]}}, w_mul_b});

    // error from the accepted angle
    logic [ERR_W-1:0] w_err;
    assign w_err = {r_setpoint[ANGLE_W-1], r_setpoint}
                 - {s_axis_tdata[ANGLE_W-1], s_axis_tdata[ANGLE_W-1:0]};

    // integral step: floor(e*dt / 2^16), saturating add
    localparam int INC_W = PROD_W - FRAC_W;
    logic [INC_W-1:0]   w_inc;
    logic [INTEG_W+1:0] w_acc;
    logic [INTEG_W-1:0] w_acc_sat;

    assign w_inc = r_prod[PROD_W-1:FRAC_W];
    assign w_acc = {{2{r_integ[INTEG_W-1]}}, r_integ}
                 + {{(INTEG_W+2-INC_W){w_inc[INC_W-1]}}, w_inc};

    always_comb begin
        if (w_acc[INTEG_W+1:INTEG_W-1] == 3'b000 || w_acc[INTEG_W+1:INTEG_W-1] == 3'b111)
            w_acc_sat = w_acc[INTEG_W-1:0];
        else if (w_acc[INTEG_W+1])
            w_acc_sat = {1'b1, {(INTEG_W-1){1'b0}}};
        else
            w_acc_sat = {1'b0, {(INTEG_W-1){1'b1}}};
    end

    // derivative division: |kd*diff| * 2^16 / dt, sign applied afterwards
    logic [PROD_W-1:0]     w_kd_abs;
    logic [DIVIDEND_W-1:0] w_dividend;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [DIVIDEND_W-1:0] w_quotient;
    logic [SUM_W-1:0]      w_q_ext;

    assign w_kd_abs    = r_prod[PROD_W-1] ? (PROD_W'(0) - r_prod) : r_prod;
    assign w_dividend  = {w_kd_abs[KD_MAG_W-1:0], {FRAC_W{1'b0}}};
    assign w_div_start = (r_state == S_DST) && (r_tick != '0);
    assign w_q_ext     = {{(SUM_W-DIVIDEND_W){1'b0}}, w_quotient};

    pbmd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_tick),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // final stage: integer magnitude, clamp, deadzone, pwm limit
    localparam int MAG_W = SUM_W - FRAC_W;
    logic [MAG_W-1:0]  w_mag_full;
    logic [CLIM_W-1:0] w_mag;
    logic [CMD_W-1:0]  w_cmd;
    logic              w_dz;
    logic [PWM_W-1:0]  w_pwm;
    logic              w_dir;
    logic              w_out_free;

    assign w_mag_full = r_sum[SUM_W-1:FRAC_W];
    assign w_mag      = (w_mag_full > MAG_W'(r_cmd_lim)) ? r_cmd_lim : w_mag_full[CLIM_W-1:0];
    assign w_cmd      = r_neg ? (CMD_W'(0) - {1'b0, w_mag}) : {1'b0, w_mag};
    assign w_dz       = (w_mag < CLIM_W'(r_deadzone));
    assign w_dir      = w_dz ? r_dir : (!r_neg && (w_mag != '0));

    always_comb begin
        if (w_dz)
            w_pwm = '0;
        else if (w_mag < CLIM_W'(r_pwm_lim))
            w_pwm = w_mag[PWM_W-1:0];
        else
            w_pwm = r_pwm_lim;
    end

    assign w_out_free = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_integ  <= '0;
            r_prev   <= '0;
            r_dir    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // output register: filled on the last step, emptied on handoff
            if (r_state == S_FIN && w_out_free)
                r_ovalid <= 1'b1;
            else if (m_axis_tready)
                r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_err   <= w_err;
                        r_state <= S_EDT;
                    end
                end
                S_EDT: begin
                    r_prod  <= w_prod;
                    r_diff  <= {r_err[ERR_W-1], r_err} - {r_prev[ERR_W-1], r_prev};
                    r_state <= S_INT;
                end
                S_INT: begin
                    r_integ <= w_acc_sat;
                    r_prod  <= w_prod;
                    r_state <= S_P;
                end
                S_P: begin
                    r_sum   <= {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                    r_prod  <= w_prod;
                    r_state <= S_I;
                end
                S_I: begin
                    r_sum   <= r_sum + {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                    r_prod  <= w_prod;
                    r_state <= S_DST;
                end
                S_DST: begin
                    r_dneg  <= r_prod[PROD_W-1];
                    // zero tick period: no derivative term
                    r_state <= (r_tick == '0) ? S_ABS : S_DWT;
                end
                S_DWT: begin
                    if (w_div_done) begin
                        r_sum   <= r_dneg ? (r_sum - w_q_ext) : (r_sum + w_q_ext);
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_sum   <= r_sum[SUM_W-1] ? (SUM_W'(0) - r_sum) : r_sum;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_prev   <= r_err;
                        r_dir    <= w_dir;
                        r_odata  <= {{(M_DATA_W-OUT_DZ_BIT-1){1'b0}}, w_dz, w_dir,
                                     w_pwm, w_cmd};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

/* hdl/pbmd_chk.sv */
// port-level checker for the balance motor pid, bound to the top level
// depends on pbmd_pkg for the result item layout
`timescale 1ns / 1ps

module pbmd_chk
    import pbmd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // one item at a time: after an accept the input side closes
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // deadzone forces zero duty
    a_dz_pwm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OUT_DZ_BIT] |->
            m_axis_tdata[OUT_PWM_LSB+PWM_W-1:OUT_PWM_LSB] == '0)
        else $error("nonzero duty inside deadzone");

    // outside the deadzone the direction follows the command sign
    a_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[OUT_DZ_BIT] |->
            m_axis_tdata[OUT_FWD_BIT] == (!m_axis_tdata[CMD_W-1]
                && m_axis_tdata[CMD_W-1:0] != '0))
        else $error("direction disagrees with command");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind pid_balance_motor_drive pbmd_chk u_pbmd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* bench/tb_top.sv */
// self-checking bench for pid_balance_motor_drive: directed ticks, then random config phases
// depends on pbmd_pkg and the pid_balance_motor_drive rtl; one item in, one result item out
`timescale 1ns / 1ps

module tb_top;
    import pbmd_pkg::*;

    localparam longint INTEG_MAX = 64'sd2147483647;
    localparam longint INTEG_MIN = -64'sd2147483648;

    // fields of one result item (not in the block's bit order)
    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [PWM_W-1:0] pwm_duty;
        logic             forward;
        logic             in_deadzone;
    } t_drive_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;    // [15:0] measured_angle
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;    // [15:0] command, [25:16] pwm_duty,
                                          // [26] forward, [27] in_deadzone
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [IDX_W-1:0]    i_cfg_addr;
    logic [CFG_W-1:0]    i_cfg_wdata;

    // register copies held by the bench
    logic [ANGLE_W-1:0]  cfg_setpoint;
    logic [GAIN_W-1:0]   cfg_gain_p;
    logic [GAIN_W-1:0]   cfg_gain_i;
    logic [GAIN_W-1:0]   cfg_gain_d;
    logic [GAIN_W-1:0]   cfg_tick;
    logic [PWM_W-1:0]    cfg_deadzone;
    logic [PWM_W-1:0]    cfg_pwm_limit;
    logic [CLIM_W-1:0]   cfg_cmd_limit;

    // controller state as the bench predicts it
    longint              integ_state;
    longint              prev_err_state;
    logic                held_forward;

    t_drive_result       expected_drive[$];
    int                  mismatch_count = 0;
    bit                  send_idle_on = 1'b1;
    bit                  recv_idle_on = 1'b1;

    pid_balance_motor_drive u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #4000000;
        $display("tb_top: errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // one control tick: error, integral, derivative, command, deadzone, pwm
    function automatic t_drive_result predict_drive(input logic [ANGLE_W-1:0] angle);
        longint        err;
        longint        dt;
        longint        acc;
        longint        dterm;
        longint        sum;
        longint        mag;
        logic          neg;
        t_drive_result r;
        err = longint'($signed(cfg_setpoint)) - longint'($signed(angle));
        dt  = longint'(cfg_tick);
        // e*dt is q8.24, floor back to q.8 before the saturating add
        acc = integ_state + ((err * dt) >>> FRAC_W);
        if (acc > INTEG_MAX)
            acc = INTEG_MAX;
        if (acc < INTEG_MIN)
            acc = INTEG_MIN;
        integ_state = acc;
        // derivative in q.16, truncated toward zero; dropped when dt is zero
        dterm = 0;
        if (dt != 0)
            dterm = (longint'(cfg_gain_d) * (err - prev_err_state) * 65536) / dt;
        prev_err_state = err;
        sum = longint'(cfg_gain_p) * err + longint'(cfg_gain_i) * acc + dterm;
        // sign-magnitude truncation toward zero, then the symmetric clamp
        neg = (sum < 0);
        mag = (neg ? -sum : sum) >>> FRAC_W;
        if (mag > longint'(cfg_cmd_limit))
            mag = longint'(cfg_cmd_limit);
        r.command     = neg ? CMD_W'(-mag) : CMD_W'(mag);
        r.in_deadzone = (mag < longint'(cfg_deadzone));
        r.pwm_duty    = '0;
        // inside the deadzone the held direction is left alone
        if (!r.in_deadzone) begin
            held_forward = !neg && (mag != 0);
            r.pwm_duty   = (mag < longint'(cfg_pwm_limit)) ? PWM_W'(mag) : cfg_pwm_limit;
        end
        r.forward = held_forward;
        return r;
    endfunction

    task automatic do_reset();
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_addr    <= REG_SETPOINT;
        i_cfg_wdata   <= '0;
        i_rst_n       <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n        <= 1'b1;
        cfg_setpoint   = RST_SETPOINT;
        cfg_gain_p     = RST_GAIN_P;
        cfg_gain_i     = RST_GAIN_I;
        cfg_gain_d     = RST_GAIN_D;
        cfg_tick       = RST_TICK;
        cfg_deadzone   = RST_DEADZONE;
        cfg_pwm_limit  = RST_PWM_LIM;
        cfg_cmd_limit  = RST_CMD_LIM;
        integ_state    = 0;
        prev_err_state = 0;
        held_forward   = 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            REG_SETPOINT:      cfg_setpoint  = val;
            REG_GAIN_P:        cfg_gain_p    = val;
            REG_GAIN_I:        cfg_gain_i    = val;
            REG_GAIN_D:        cfg_gain_d    = val;
            REG_TICK_PERIOD:   cfg_tick      = val;
            REG_DEADZONE:      cfg_deadzone  = val[PWM_W-1:0];
            REG_PWM_LIMIT:     cfg_pwm_limit = val[PWM_W-1:0];
            REG_COMMAND_LIMIT: cfg_cmd_limit = val[CLIM_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [15:0] sp, input logic [15:0] kp,
                                input logic [15:0] ki, input logic [15:0] kd,
                                input logic [15:0] dt, input logic [15:0] dz,
                                input logic [15:0] pl, input logic [15:0] cl);
        write_reg(REG_SETPOINT, sp);
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_TICK_PERIOD, dt);
        write_reg(REG_DEADZONE, dz);
        write_reg(REG_PWM_LIMIT, pl);
        write_reg(REG_COMMAND_LIMIT, cl);
    endtask

    // random gap before each item; valid stays up when the gap is zero
    task automatic send_angle(input logic [ANGLE_W-1:0] angle);
        int gap;
        gap = send_idle_on ? $urandom_range(11, 0) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= angle;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        expected_drive.push_back(predict_drive(angle));
    endtask

    // stop sending and wait for every outstanding result item
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_drive.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(3, 0))
            0:       return $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
            default: return GAIN_W'($urandom_range(1024, 0));
        endcase
    endfunction

    // mostly near the setpoint so the deadzone and the sign flips get hit
    function automatic logic [ANGLE_W-1:0] pick_angle();
        logic [ANGLE_W-1:0] corners [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        case ($urandom_range(7, 0)) inside
            [0:2]:   return cfg_setpoint + ANGLE_W'($urandom_range(4095, 0) - 2048);
            [3:4]:   return ANGLE_W'($urandom);
            5:       return corners[$urandom_range(3, 0)];
            default: return cfg_setpoint + ANGLE_W'($urandom_range(255, 0) - 128);
        endcase
    endfunction

    // default gains straight out of reset, angle corners
    task automatic test_reset_defaults();
        send_angle(16'h0000);
        send_angle(16'h7FFF);
        send_angle(16'h8000);
        send_angle(16'h0001);
        send_angle(16'hFFFF);
        drain_results();
    endtask

    // pure p with unit gain: command is the error in whole degrees
    task automatic test_deadzone_direction();
        apply_config(16'h0000, 16'd256, 16'd0, 16'd0, 16'd655, 16'd5, 16'd3, 16'd8);
        send_angle(16'hF600);   // +10 clamps to 8, forward, pwm at limit
        send_angle(16'hFC00);   // +4 inside deadzone, direction held
        send_angle(16'h0600);   // -6, backward
        send_angle(16'hFB00);   // exactly the deadzone is outside it
        send_angle(16'hFA01);   // 5.99 truncates to 5
        send_angle(16'h05FF);   // -5.99 truncates toward zero to -5
        send_angle(16'h00FF);   // magnitude below one rounds to zero
        drain_results();
        // zero deadzone: a zero command drives backward with zero pwm
        write_reg(REG_DEADZONE, 16'd0);
        send_angle(16'h0000);
        drain_results();
    endtask

    // zero tick period: no integral growth, derivative skipped
    task automatic test_zero_tick();
        apply_config(16'h0400, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'd0, 16'd999,
                     16'd32767);
        send_angle(16'h8000);
        send_angle(16'h7FFF);
        send_angle(16'h0400);
        drain_results();
    endtask

    // setpoint, gains, tick period and command limit at their top end, largest error swings
    task automatic test_full_scale();
        apply_config(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd999, 16'd999,
                     16'd32767);
        send_angle(16'h8000);
        send_angle(16'h8000);
        send_angle(16'h8000);
        send_angle(16'h7FFF);
        send_angle(16'h7FFF);
        drain_results();
        write_reg(REG_COMMAND_LIMIT, 16'd0);
        send_angle(16'h8000);
        drain_results();
    endtask

    // random phases, each with its own register set; one phase runs without idling
    task automatic test_random_phases();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: apply_config(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0,
                                16'd0, 16'd0);
                1: apply_config(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd999,
                                16'd999, 16'd32767);
                default: begin
                    apply_config(16'($urandom), pick_gain(), pick_gain(), pick_gain(),
                                 ($urandom_range(3, 0) == 0) ? 16'($urandom_range(1, 0) * 16'hFFFF)
                                                             : 16'($urandom_range(2000, 1)),
                                 ($urandom_range(3, 0) == 0) ? 16'($urandom_range(999, 0))
                                                             : 16'($urandom_range(40, 0)),
                                 16'($urandom_range(999, 0)),
                                 $urandom_range(1, 0) ? 16'($urandom_range(32767, 0))
                                                      : 16'($urandom_range(1200, 0)));
                end
            endcase
            send_idle_on = (phase != 3);
            recv_idle_on = (phase != 3);
            for (int n = 0; n < 75; n++) begin
                // mid-phase hold-off until the pipeline is empty
                if (n == 40)
                    drain_results();
                send_angle(pick_angle());
            end
            drain_results();
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    // result side: random stall before each item
    initial begin : result_sink
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = recv_idle_on ? $urandom_range(11, 0) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // compare every accepted result item against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_drive_result got;
        t_drive_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.command     = m_axis_tdata[OUT_CMD_LSB +: CMD_W];
            got.pwm_duty    = m_axis_tdata[OUT_PWM_LSB +: PWM_W];
            got.forward     = m_axis_tdata[OUT_FWD_BIT];
            got.in_deadzone = m_axis_tdata[OUT_DZ_BIT];
            if (expected_drive.size() == 0) begin
                report_mismatch($sformatf("result item %h with none pending", m_axis_tdata));
            end else begin
                want = expected_drive.pop_front();
                if (got.command !== want.command)
                    report_mismatch($sformatf("command %0d, want %0d",
                                              $signed(got.command), $signed(want.command)));
                if (got.pwm_duty !== want.pwm_duty)
                    report_mismatch($sformatf("pwm_duty %0d, want %0d",
                                              got.pwm_duty, want.pwm_duty));
                if (got.forward !== want.forward)
                    report_mismatch($sformatf("forward %b, want %b",
                                              got.forward, want.forward));
                if (got.in_deadzone !== want.in_deadzone)
                    report_mismatch($sformatf("in_deadzone %b, want %b",
                                              got.in_deadzone, want.in_deadzone));
            end
        end
    end

    initial begin
        do_reset();
        test_reset_defaults();
        test_deadzone_direction();
        test_zero_tick();
        test_full_scale();
        test_random_phases();
        drain_results();
        // slack for anything stray
        repeat (120) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
